### rtl/core/jve_pkg.sv
// Shared types and constants for the joint velocity estimator.
package jve_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_MUL,
    S_DIV,
    S_FIN,
    S_EREAD,
    S_EOUT
  } state_t;

  localparam int unsigned POS_W   = 32;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned USEC_W  = 20;
  localparam int unsigned MAG_W   = POS_W + 1;
  localparam int unsigned PROD_W  = MAG_W + USEC_W;
  localparam int unsigned DCNT_W  = 6;

  localparam logic [USEC_W-1:0] USEC_PER_SEC = USEC_W'(1000000);
  localparam logic [PROD_W-1:0] VEL_POS_MAX  = PROD_W'(64'h7FFF_FFFF);
  localparam logic [PROD_W-1:0] VEL_NEG_MAX  = PROD_W'(64'h8000_0000);

endpackage

### rtl/core/joint_velocity_estimator.sv
// Joint velocity estimator: finite-difference velocity per joint over sweeps.
//
// Input: one item per joint, accepted when start is high and busy is low.
// Items without in_last_joint leave busy low and start nothing. The item
// with in_last_joint set also carries the sweep id and sweep validity and
// starts processing; busy is high until all JOINTS results have gone out.
// Results: JOINTS items, each shown for one cycle with out_valid, between
// cache reads; out_last_result marks the final one. The receiver cannot
// stall, results are never held.
// Processing: computed sweeps run read, evaluate, multiply, 53 divide steps
// and finish for each joint in turn, on the one-bit-per-cycle divider
// shared by all joints, then the result sweep. Priming runs read and
// evaluate for each joint before the result sweep; invalid and repeated
// sweeps go straight to the result sweep.
// State lives in small synchronous memories (staged, prior, cached) that
// are read one entry at a time into registered outputs.
// Reset (rst_n low, synchronous) returns to idle, unprimed, with an empty
// cache and the interval window at 100 to 100000 us. The window registers
// are written by cfg_we/cfg_index/cfg_data; users keep to idle, not enforced.
module joint_velocity_estimator #(
  parameter int unsigned JOINTS = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_joint_position,
  input  logic [31:0]        in_sample_time_us,
  input  logic [31:0]        in_sweep_number,
  input  logic               in_sweep_ok,
  input  logic               in_last_joint,
  output logic               out_valid,
  output logic signed [31:0] out_joint_velocity,
  output logic               out_estimate_valid,
  output logic               out_estimate_repeated,
  output logic               out_last_result
);

  localparam int unsigned JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int unsigned CW = $clog2(JOINTS + 1);
  localparam int unsigned PW = jve_pkg::PROD_W;
  localparam int unsigned MW = jve_pkg::MAG_W;
  localparam logic [JW-1:0] IDX_LAST = JW'(JOINTS - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(JOINTS);

  localparam logic CFG_MIN = 1'b0;
  localparam logic CFG_MAX = 1'b1;

  logic [63:0] stage_mem [JOINTS];
  logic [63:0] prior_mem [JOINTS];
  logic [31:0] cache_mem [JOINTS];
  logic [63:0] stage_q;
  logic [63:0] prior_q;
  logic [31:0] cache_q;

  jve_pkg::state_t state_r, state_nxt;
  logic [JW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] lcnt_r, lcnt_nxt;
  logic [CW-1:0] lim_r, lim_nxt;
  logic [CW-1:0] fidx_r, fidx_nxt;
  logic [31:0]   sweep_r, sweep_nxt;
  logic [31:0]   psweep_r, psweep_nxt;
  logic [31:0]   min_r, max_r;
  logic          prime_r, prime_nxt;
  logic          failed_r, failed_nxt;
  logic          primed_r, primed_nxt;
  logic          cvalid_r, cvalid_nxt;
  logic          oval_r, oval_nxt;
  logic          orep_r, orep_nxt;
  logic          neg_r, neg_nxt;
  logic [MW-1:0] mag_r, mag_nxt;
  logic [31:0]   dt_r, dt_nxt;
  logic [PW-1:0] divn_r, divn_nxt;
  logic [PW-1:0] quo_r, quo_nxt;
  logic [32:0]   rem_r, rem_nxt;
  logic [jve_pkg::DCNT_W-1:0] dcnt_r, dcnt_nxt;

  logic          accept;
  logic          stage_we;
  logic          prior_we;
  logic          cache_we;
  logic          rd_stage;
  logic          rd_cache;
  logic [31:0]   vel;
  logic [31:0]   dt;
  logic [MW-1:0] diff;
  logic [32:0]   rem_sh;
  logic          ovf;

  assign accept   = start && !busy;
  assign busy     = (state_r != jve_pkg::S_IDLE);
  assign stage_we = accept && (lcnt_r < CNT_FULL);

  always_ff @(posedge clk) begin
    if (stage_we) begin
      stage_mem[lcnt_r[JW-1:0]] <= {in_joint_position, in_sample_time_us};
    end
    if (prior_we) begin
      prior_mem[idx_r] <= stage_q;
    end
    if (cache_we) begin
      cache_mem[idx_r] <= vel;
    end
    if (rd_stage) begin
      stage_q <= stage_mem[idx_r];
      prior_q <= prior_mem[idx_r];
    end
    if (rd_cache) begin
      cache_q <= cache_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= 32'd100;
      max_r <= 32'd100000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN: min_r <= cfg_data;
        CFG_MAX: max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= jve_pkg::S_IDLE;
      idx_r    <= '0;
      lcnt_r   <= '0;
      primed_r <= 1'b0;
      psweep_r <= '0;
      cvalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      lcnt_r   <= lcnt_nxt;
      primed_r <= primed_nxt;
      psweep_r <= psweep_nxt;
      cvalid_r <= cvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lim_r    <= lim_nxt;
    fidx_r   <= fidx_nxt;
    sweep_r  <= sweep_nxt;
    prime_r  <= prime_nxt;
    failed_r <= failed_nxt;
    oval_r   <= oval_nxt;
    orep_r   <= orep_nxt;
    neg_r    <= neg_nxt;
    mag_r    <= mag_nxt;
    dt_r     <= dt_nxt;
    divn_r   <= divn_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    dcnt_r   <= dcnt_nxt;
  end

  assign dt     = stage_q[31:0] - prior_q[31:0];
  assign diff   = {stage_q[63], stage_q[63:32]} - {prior_q[63], prior_q[63:32]};
  assign rem_sh = {rem_r[31:0], divn_r[PW-1]};
  assign ovf    = neg_r ? (quo_r > jve_pkg::VEL_NEG_MAX) : (quo_r > jve_pkg::VEL_POS_MAX);
  assign vel    = neg_r ? (32'd0 - quo_r[31:0]) : quo_r[31:0];

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    lcnt_nxt   = lcnt_r;
    lim_nxt    = lim_r;
    fidx_nxt   = fidx_r;
    sweep_nxt  = sweep_r;
    psweep_nxt = psweep_r;
    prime_nxt  = prime_r;
    failed_nxt = failed_r;
    primed_nxt = primed_r;
    cvalid_nxt = cvalid_r;
    oval_nxt   = oval_r;
    orep_nxt   = orep_r;
    neg_nxt    = neg_r;
    mag_nxt    = mag_r;
    dt_nxt     = dt_r;
    divn_nxt   = divn_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    dcnt_nxt   = dcnt_r;
    prior_we   = 1'b0;
    cache_we   = 1'b0;
    rd_stage   = 1'b0;
    rd_cache   = 1'b0;

    case (state_r)
      jve_pkg::S_IDLE: begin
        if (accept) begin
          if (stage_we) begin
            lcnt_nxt = lcnt_r + 1'b1;
          end
          if (in_last_joint) begin
            lcnt_nxt   = '0;
            idx_nxt    = '0;
            sweep_nxt  = in_sweep_number;
            failed_nxt = 1'b0;
            lim_nxt    = '0;
            oval_nxt   = 1'b0;
            orep_nxt   = 1'b0;
            if (!in_sweep_ok) begin
              primed_nxt = 1'b0;
              psweep_nxt = '0;
              cvalid_nxt = 1'b0;
              state_nxt  = jve_pkg::S_EREAD;
            end else if (primed_r && in_sweep_number == psweep_r) begin
              lim_nxt   = cvalid_r ? CNT_FULL : '0;
              oval_nxt  = cvalid_r;
              orep_nxt  = 1'b1;
              state_nxt = jve_pkg::S_EREAD;
            end else begin
              prime_nxt = !primed_r || in_sweep_number == '0;
              state_nxt = jve_pkg::S_READ;
            end
          end
        end
      end

      jve_pkg::S_READ: begin
        rd_stage  = 1'b1;
        state_nxt = jve_pkg::S_EVAL;
      end

      jve_pkg::S_EVAL: begin
        dt_nxt  = dt;
        neg_nxt = diff[MW-1];
        mag_nxt = diff[MW-1] ? (MW'(0) - diff) : diff;
        if (!prime_r && !failed_r && (dt < min_r || dt > max_r)) begin
          failed_nxt = 1'b1;
          fidx_nxt   = CW'(idx_r);
          prior_we   = 1'b1;
        end else if (!prime_r && !failed_r && dt == '0) begin
          primed_nxt = 1'b0;
          psweep_nxt = '0;
          cvalid_nxt = 1'b0;
          idx_nxt    = '0;
          state_nxt  = jve_pkg::S_EREAD;
        end else if (!prime_r && !failed_r) begin
          state_nxt = jve_pkg::S_MUL;
        end else begin
          prior_we = 1'b1;
        end
      end

      jve_pkg::S_MUL: begin
        divn_nxt  = mag_r * jve_pkg::USEC_PER_SEC;
        quo_nxt   = '0;
        rem_nxt   = '0;
        dcnt_nxt  = '0;
        state_nxt = jve_pkg::S_DIV;
      end

      jve_pkg::S_DIV: begin
        divn_nxt = divn_r << 1;
        if (rem_sh >= {1'b0, dt_r}) begin
          rem_nxt = rem_sh - {1'b0, dt_r};
          quo_nxt = {quo_r[PW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          quo_nxt = {quo_r[PW-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == jve_pkg::DCNT_W'(PW - 1)) begin
          state_nxt = jve_pkg::S_FIN;
        end
      end

      jve_pkg::S_FIN: begin
        if (ovf) begin
          primed_nxt = 1'b0;
          psweep_nxt = '0;
          cvalid_nxt = 1'b0;
          idx_nxt    = '0;
          state_nxt  = jve_pkg::S_EREAD;
        end else begin
          prior_we = 1'b1;
          cache_we = 1'b1;
        end
      end

      jve_pkg::S_EREAD: begin
        rd_cache  = 1'b1;
        state_nxt = jve_pkg::S_EOUT;
      end

      jve_pkg::S_EOUT: begin
        if (idx_r == IDX_LAST) begin
          state_nxt = jve_pkg::S_IDLE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = jve_pkg::S_EREAD;
        end
      end

      default: state_nxt = jve_pkg::S_IDLE;
    endcase

    // advance to the next joint once this one's prior entry is written
    if (prior_we) begin
      if (idx_r == IDX_LAST) begin
        idx_nxt    = '0;
        psweep_nxt = sweep_r;
        state_nxt  = jve_pkg::S_EREAD;
        if (prime_r) begin
          primed_nxt = 1'b1;
        end else begin
          lim_nxt    = (failed_r || failed_nxt) ? fidx_nxt : CNT_FULL;
          oval_nxt   = !(failed_r || failed_nxt);
          cvalid_nxt = !(failed_r || failed_nxt);
        end
      end else begin
        idx_nxt   = idx_r + 1'b1;
        state_nxt = jve_pkg::S_READ;
      end
    end
  end

  assign out_valid             = (state_r == jve_pkg::S_EOUT);
  assign out_joint_velocity    = (CW'(idx_r) < lim_r) ? cache_q : '0;
  assign out_estimate_valid    = oval_r;
  assign out_estimate_repeated = orep_r;
  assign out_last_result       = out_valid && (idx_r == IDX_LAST);

endmodule

### rtl/core/jve_checker.sv
// Port-level checks for the joint velocity estimator, bound to the top level.
module jve_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_last_joint,
  input logic out_valid,
  input logic out_last_result
);

  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result item while not busy");

  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_last_joint |=> busy) else $error("last item did not start a sweep");

  a_last_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_result |-> out_valid) else $error("last flag without strobe");

  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_result |=> !out_valid && !busy) else $error("items after last result");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid) else $error("not idle after reset");

endmodule

bind joint_velocity_estimator jve_checker u_jve_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_last_joint   (in_last_joint),
  .out_valid       (out_valid),
  .out_last_result (out_last_result)
);

### tb/sv/jve_checker.sv
`timescale 1ns / 1ps
// Checker for the joint velocity estimator: predicts every result item and compares it.
module jve_scoreboard #(
  parameter int unsigned JOINTS = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] in_joint_position,
  input  logic [31:0]        in_sample_time_us,
  input  logic [31:0]        in_sweep_number,
  input  logic               in_sweep_ok,
  input  logic               in_last_joint,
  input  logic               out_valid,
  input  logic signed [31:0] out_joint_velocity,
  input  logic               out_estimate_valid,
  input  logic               out_estimate_repeated,
  input  logic               out_last_result,
  output int                 fail_count,
  output int                 pending_count
);

  typedef struct packed {
    logic [31:0] vel;
    logic        valid;
    logic        rep;
    logic        last;
  } vel_result_t;

  localparam int CFG_MIN = 0;
  localparam int CFG_MAX = 1;

  vel_result_t  velocity_q[$];
  logic [31:0]  win_min, win_max;
  logic [31:0]  stage_pos [JOINTS];
  logic [31:0]  stage_time[JOINTS];
  logic [31:0]  prev_pos  [JOINTS];
  logic [31:0]  prev_time [JOINTS];
  logic [31:0]  cache_vel [JOINTS];
  logic         cache_ok, is_primed;
  logic [31:0]  prev_sweep;
  int unsigned  fill;

  assign pending_count = velocity_q.size();

  function automatic void clear_history();
    for (int j = 0; j < JOINTS; j++) begin
      prev_pos[j] = '0; prev_time[j] = '0; cache_vel[j] = '0;
    end
    cache_ok = 1'b0; prev_sweep = '0; is_primed = 1'b0;
  endfunction

  function automatic void adopt_staged(logic [31:0] sw);
    for (int j = 0; j < JOINTS; j++) begin
      prev_pos[j] = stage_pos[j]; prev_time[j] = stage_time[j];
    end
    prev_sweep = sw;
  endfunction

  function automatic void predict_sweep(logic [31:0] pos, logic [31:0] ts, logic [31:0] sw,
                                        logic ok, logic last);
    logic [31:0] vel[JOINTS];
    logic        valid, rep, win_fail, ovf, neg;
    logic [31:0] dt;
    longint      diff;
    logic [63:0] mag;
    vel_result_t r;
    valid = 0; rep = 0; win_fail = 0; ovf = 0;
    if (fill < JOINTS) begin
      stage_pos[fill] = pos; stage_time[fill] = ts; fill++;
    end
    if (!last) return;
    fill = 0;
    for (int j = 0; j < JOINTS; j++) vel[j] = '0;
    if (!ok) clear_history();
    else if (is_primed && sw == prev_sweep) begin
      for (int j = 0; j < JOINTS; j++) vel[j] = cache_vel[j];
      valid = cache_ok; rep = 1;
    end else if (!is_primed || sw == 0) begin
      adopt_staged(sw); is_primed = 1;
    end else begin
      for (int j = 0; j < JOINTS; j++) begin
        dt = stage_time[j] - prev_time[j];
        if (dt < win_min || dt > win_max) begin win_fail = 1; break; end
        if (dt == 0) begin ovf = 1; break; end
        diff = longint'($signed(stage_pos[j])) - longint'($signed(prev_pos[j]));
        neg = diff < 0;
        mag = 64'(neg ? -diff : diff) * 64'd1000000;
        mag = mag / 64'(dt);
        if ((!neg && mag > 64'h7FFF_FFFF) || (neg && mag > 64'h8000_0000)) begin
          ovf = 1; break;
        end
        vel[j] = neg ? 32'(-mag) : 32'(mag);
      end
      if (ovf) begin
        clear_history();
        for (int j = 0; j < JOINTS; j++) vel[j] = '0;
      end else if (win_fail) begin
        adopt_staged(sw);
        for (int j = 0; j < JOINTS; j++) cache_vel[j] = '0;
        cache_ok = 0;
      end else begin
        adopt_staged(sw); valid = 1;
        for (int j = 0; j < JOINTS; j++) cache_vel[j] = vel[j];
        cache_ok = 1;
      end
    end
    for (int j = 0; j < JOINTS; j++) begin
      r.vel = vel[j]; r.valid = valid; r.rep = rep; r.last = (j == JOINTS - 1);
      velocity_q.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    vel_result_t e;
    if (!rst_n) begin
      win_min <= 32'd100; win_max <= 32'd100000;
      for (int j = 0; j < JOINTS; j++) begin
        stage_pos[j] = '0; stage_time[j] = '0;
      end
      clear_history();
      fill = 0;
      velocity_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == 1'(CFG_MIN)) win_min <= cfg_data;
        else if (cfg_index == 1'(CFG_MAX)) win_max <= cfg_data;
      end
      if (out_valid) begin
        if (velocity_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result item vel=%h", out_joint_velocity);
        end else begin
          e = velocity_q.pop_front();
          if (e.vel !== out_joint_velocity || e.valid !== out_estimate_valid ||
              e.rep !== out_estimate_repeated || e.last !== out_last_result) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: exp vel=%h v=%b r=%b l=%b got vel=%h v=%b r=%b l=%b",
                       e.vel, e.valid, e.rep, e.last, out_joint_velocity,
                       out_estimate_valid, out_estimate_repeated, out_last_result);
          end
        end
      end
      if (start && !busy)
        predict_sweep(in_joint_position, in_sample_time_us, in_sweep_number,
                      in_sweep_ok, in_last_joint);
    end
  end

endmodule

### tb/sv/tb_joint_velocity_estimator.sv
`timescale 1ns / 1ps
// Top of the joint velocity estimator testbench: clock, reset, stimulus and verdict.
module tb_joint_velocity_estimator;

  localparam int JOINTS = 7;
  localparam int CFG_MIN = 0;
  localparam int CFG_MAX = 1;
  localparam int WATCHDOG = 20000;

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0, cfg_index = 0;
  logic [31:0] cfg_data = '0;
  logic start = 0;
  logic busy;
  logic signed [31:0] in_joint_position = '0;
  logic [31:0] in_sample_time_us = '0, in_sweep_number = '0;
  logic in_sweep_ok = 0, in_last_joint = 0;
  logic out_valid, out_estimate_valid, out_estimate_repeated, out_last_result;
  logic signed [31:0] out_joint_velocity;
  int fail_count, pending_count;
  int idle_pct = 28;
  int quiet = 0;
  logic [31:0] base_pos[JOINTS];
  logic [31:0] clock_us;
  logic [31:0] sweep_num;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  joint_velocity_estimator #(.JOINTS(JOINTS)) dut (.*);
  jve_scoreboard #(.JOINTS(JOINTS)) u_check (.*);

  always @(posedge clk) begin
    if (out_valid || (start && !busy) || cfg_we) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > WATCHDOG) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // start stays high after an accepted item until the next call drives it
  task automatic send_item(logic [31:0] pos, logic [31:0] ts, logic [31:0] sw, logic ok,
                           logic last);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1; in_joint_position <= pos; in_sample_time_us <= ts;
    in_sweep_number <= sw; in_sweep_ok <= ok; in_last_joint <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (pending_count != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_window(logic [31:0] lo, logic [31:0] hi);
    cfg_we <= 1; cfg_index <= 1'(CFG_MIN); cfg_data <= lo;
    @(posedge clk);
    cfg_index <= 1'(CFG_MAX); cfg_data <= hi;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // Full sweep: positions drift from the base by up to +/-span, common dt;
  // now and then one extra item past the last joint is sent as the last item
  task automatic good_sweep(logic [31:0] dt, int span, logic [31:0] sw, logic ok);
    logic extra;
    logic fin;
    extra = ($urandom_range(7) == 0);
    clock_us += dt;
    for (int j = 0; j < JOINTS; j++) begin
      fin = (j == JOINTS - 1) && !extra;
      base_pos[j] += 32'($signed($urandom_range(2 * span)) - span);
      send_item(base_pos[j], clock_us + (($urandom_range(99) < 5) ? $urandom : 0),
                fin ? sw : (($urandom_range(99) < 10) ? $urandom : 32'h0),
                fin ? ok : 1'($urandom), fin);
    end
    if (extra) send_item($urandom, $urandom, sw, ok, 1'b1);
  endtask

  initial begin
    logic [31:0] dt;
    for (int j = 0; j < JOINTS; j++) base_pos[j] = $urandom;
    clock_us = $urandom;
    sweep_num = 1;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed: priming, compute, repeat, extremes, invalid, sweep zero, overflow
    good_sweep(1000, 1000, sweep_num, 1);
    good_sweep(1000, 1000, ++sweep_num, 1);
    good_sweep(1000, 1000, sweep_num, 1);
    for (int j = 0; j < JOINTS; j++) begin
      clock_us += 100;
      send_item(j[0] ? 32'h7FFF_FFFF : 32'h8000_0000, clock_us, 32'hFFFF_FFFF, 1, 1'b0);
    end
    send_item(0, 0, 32'hFFFF_FFFF, 1, 1);
    good_sweep(100000, 1, ++sweep_num, 1);
    good_sweep(100001, 1, ++sweep_num, 1);
    good_sweep(50, 1, ++sweep_num, 1);
    good_sweep(1000, 1, 0, 1);
    good_sweep(1000, 1, ++sweep_num, 0);
    drain();
    write_window(0, 32'hFFFF_FFFF);
    good_sweep(1000, 5, ++sweep_num, 1);
    good_sweep(0, 5, ++sweep_num, 1);
    drain();
    write_window(500, 400);
    good_sweep(1000, 5, ++sweep_num, 1);
    good_sweep(1000, 5, ++sweep_num, 1);
    drain();
    write_window(100, 100000);
    // Random sweeps, some short
    for (int s = 0; s < 18; s++) begin
      if (s == 6) idle_pct = 0;
      if (s == 12) idle_pct = 28;
      if (s == 14) drain();
      case ($urandom_range(9))
        0: good_sweep($urandom_range(2000, 90), 1 << $urandom_range(28), sweep_num, 1);
        1: good_sweep(1000, 5000, ++sweep_num, $urandom_range(3) != 0);
        2: begin
          for (int j = 0; j < $urandom_range(JOINTS - 1); j++)
            send_item($urandom, clock_us + 1000, $urandom, 1'($urandom), 0);
          clock_us += 1000;
          send_item($urandom, clock_us, ++sweep_num, 1, 1);
        end
        default: begin
          dt = ($urandom_range(9) == 0) ? $urandom : $urandom_range(5000, 100);
          good_sweep(dt, 1 << $urandom_range(20), ++sweep_num, 1);
        end
      endcase
    end
    drain();
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
